>>> rtl/bcma_pkg.sv
package bcma_pkg;

  localparam int NUM_CLASSES = 3;
  localparam int CNT_W       = 4;
  localparam int MASS_W      = 4;
  localparam int TOTAL_W     = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 4;

  localparam logic [CNT_W-1:0] MAX_PER_CLASS = 4'd15;

  localparam logic [MASS_W-1:0] RESET_MASS [NUM_CLASSES] = '{4'd2, 4'd3, 4'd5};
  localparam logic [CNT_W-1:0]  RESET_STOCK [NUM_CLASSES] = '{4'd4, 4'd4, 4'd5};

  localparam logic [CFG_IDX_W-1:0] CFG_MASS0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASS1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASS2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOCK0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STOCK1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STOCK2 = 3'd5;

  typedef struct packed {
    logic               mode;
    logic [TOTAL_W-1:0] requested_total;
    logic [CNT_W-1:0]   returned0;
    logic [CNT_W-1:0]   returned1;
    logic [CNT_W-1:0]   returned2;
  } bcma_in_t;

  typedef struct packed {
    logic             granted;
    logic [CNT_W-1:0] grant0;
    logic [CNT_W-1:0] grant1;
    logic [CNT_W-1:0] grant2;
    logic [CNT_W-1:0] stock_after0;
    logic [CNT_W-1:0] stock_after1;
    logic [CNT_W-1:0] stock_after2;
  } bcma_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SEARCH,
    ST_COMMIT
  } bcma_state_e;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
    logic commit;
  } bcma_cmd_t;

  typedef struct packed {
    logic mode_ret;
    logic hit;
    logic last;
  } bcma_sts_t;

endpackage

>>> rtl/bcma_ctrl.sv
module bcma_ctrl
  import bcma_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  input  bcma_sts_t sts_i,
  output bcma_cmd_t cmd_o
);

  bcma_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        state_d = sts_i.mode_ret ? ST_COMMIT : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (sts_i.hit || sts_i.last) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_SETUP:  cmd_o.setup = 1'b1;
      ST_SEARCH: cmd_o.step = 1'b1;
      ST_COMMIT: cmd_o.commit = out_free;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign out_valid_d = cmd_o.commit ? 1'b1 : (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/bcma_dpath.sv
module bcma_dpath
  import bcma_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  bcma_in_t              in_data_i,
  input  bcma_cmd_t             cmd_i,
  output bcma_sts_t             sts_o,
  output bcma_out_t             out_data_o
);

  logic [MASS_W-1:0]  mass_q  [NUM_CLASSES];
  logic [CNT_W-1:0]   stock_q [NUM_CLASSES];
  logic [CNT_W-1:0]   stock_d [NUM_CLASSES];
  bcma_in_t           item_q;
  logic [CNT_W-1:0]   a_q, b_q, lim1_q, lim0_q;
  logic [TOTAL_W-1:0] u2_q, u1_q, u1_top_q;
  logic               ok_q;
  logic [CNT_W-1:0]   c2_q, c1_q, c0_q;
  bcma_out_t          out_q;

  logic [CNT_W-1:0]   lim2, lim1;
  logic [TOTAL_W+1:0] diff;
  logic               neg, zero_hit, mul_hit, hit, last;
  logic [TOTAL_W-1:0] rem;
  logic [CNT_W-1:0]   c0;
  logic [CNT_W-1:0]   ret [NUM_CLASSES];
  logic [CNT_W:0]     sum;

  assign lim2 = (mass_q[2] != '0) ? stock_q[2] : '0;
  assign lim1 = (mass_q[1] != '0) ? stock_q[1] : '0;

  // remaining mass for the current candidate, negative when it overshoots
  assign diff = {2'b00, item_q.requested_total} - {2'b00, u2_q} - {2'b00, u1_q};
  assign neg  = diff[TOTAL_W+1];
  assign rem  = diff[TOTAL_W-1:0];
  assign zero_hit = !neg && (rem == '0);

  // class 0 count: rem must equal one of the multiples within stock
  always_comb begin
    logic [TOTAL_W-1:0] mult;
    c0      = '0;
    mul_hit = 1'b0;
    for (int k = 1; k <= int'(MAX_PER_CLASS); k++) begin
      mult = TOTAL_W'(k) * {{(TOTAL_W-MASS_W){1'b0}}, mass_q[0]};
      if (!neg && !zero_hit && (CNT_W'(k) <= lim0_q) && (rem == mult)) begin
        c0      = c0 | CNT_W'(k);
        mul_hit = 1'b1;
      end
    end
  end

  assign hit  = zero_hit || mul_hit;
  assign last = (a_q == '0) && (b_q == '0);

  assign sts_o.mode_ret = item_q.mode;
  assign sts_o.hit      = hit;
  assign sts_o.last     = last;

  assign ret[0] = item_q.returned0;
  assign ret[1] = item_q.returned1;
  assign ret[2] = item_q.returned2;

  always_comb begin
    sum = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      sum = {1'b0, stock_q[i]} + {1'b0, ret[i]};
      if (item_q.mode) begin
        stock_d[i] = (sum > {1'b0, MAX_PER_CLASS}) ? MAX_PER_CLASS : sum[CNT_W-1:0];
      end else begin
        stock_d[i] = stock_q[i];
      end
    end
    if (!item_q.mode && ok_q) begin
      stock_d[0] = stock_q[0] - c0_q;
      stock_d[1] = stock_q[1] - c1_q;
      stock_d[2] = stock_q[2] - c2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        mass_q[i]  <= RESET_MASS[i];
        stock_q[i] <= RESET_STOCK[i];
      end
    end else if (cmd_i.commit) begin
      for (int i = 0; i < NUM_CLASSES; i++) stock_q[i] <= stock_d[i];
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MASS0:  mass_q[0] <= cfg_wdata_i;
        CFG_MASS1:  mass_q[1] <= cfg_wdata_i;
        CFG_MASS2:  mass_q[2] <= cfg_wdata_i;
        CFG_STOCK0: stock_q[0] <= (cfg_wdata_i > MAX_PER_CLASS) ? MAX_PER_CLASS : cfg_wdata_i;
        CFG_STOCK1: stock_q[1] <= (cfg_wdata_i > MAX_PER_CLASS) ? MAX_PER_CLASS : cfg_wdata_i;
        CFG_STOCK2: stock_q[2] <= (cfg_wdata_i > MAX_PER_CLASS) ? MAX_PER_CLASS : cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
    if (cmd_i.setup) begin
      a_q      <= lim2;
      b_q      <= lim1;
      lim1_q   <= lim1;
      lim0_q   <= (mass_q[0] != '0) ? stock_q[0] : '0;
      u2_q     <= {{(TOTAL_W-CNT_W){1'b0}}, lim2} * {{(TOTAL_W-MASS_W){1'b0}}, mass_q[2]};
      u1_q     <= {{(TOTAL_W-CNT_W){1'b0}}, lim1} * {{(TOTAL_W-MASS_W){1'b0}}, mass_q[1]};
      u1_top_q <= {{(TOTAL_W-CNT_W){1'b0}}, lim1} * {{(TOTAL_W-MASS_W){1'b0}}, mass_q[1]};
      ok_q     <= 1'b1;
      c2_q     <= '0;
      c1_q     <= '0;
      c0_q     <= '0;
    end
    if (cmd_i.step) begin
      ok_q <= hit;
      c2_q <= hit ? a_q : '0;
      c1_q <= hit ? b_q : '0;
      c0_q <= hit ? c0 : '0;
      // walk class 1 down fastest, then class 2
      if (!hit && !last) begin
        if (b_q == '0) begin
          a_q  <= a_q - 1'b1;
          u2_q <= u2_q - {{(TOTAL_W-MASS_W){1'b0}}, mass_q[2]};
          b_q  <= lim1_q;
          u1_q <= u1_top_q;
        end else begin
          b_q  <= b_q - 1'b1;
          u1_q <= u1_q - {{(TOTAL_W-MASS_W){1'b0}}, mass_q[1]};
        end
      end
    end
    if (cmd_i.commit) begin
      out_q.granted      <= item_q.mode ? 1'b1 : ok_q;
      out_q.grant0       <= item_q.mode ? '0 : c0_q;
      out_q.grant1       <= item_q.mode ? '0 : c1_q;
      out_q.grant2       <= item_q.mode ? '0 : c2_q;
      out_q.stock_after0 <= stock_d[0];
      out_q.stock_after1 <= stock_d[1];
      out_q.stock_after2 <= stock_d[2];
    end
  end

  assign out_data_o = out_q;

endmodule

>>> rtl/bounded_change_making_allocator_core.sv
// a return item passes through the setup and commit states after acceptance, a
// request through setup, a search walking one (class 2, class 1) count pair
// per cycle, at most 16 x 16 pairs, and then commit; the result is registered.
// throughput: one item at a time, the next is taken the cycle after commit.
// reset: masses load 2, 3, 5 and stocks 4, 4, 5; no item or result is pending.
module bounded_change_making_allocator_core
  import bcma_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  bcma_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bcma_out_t             out_data_o
);

  bcma_cmd_t cmd;
  bcma_sts_t sts;

  bcma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bcma_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block took no work after an accepted item");

  a_commit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> in_stall_o)
    else $error("commit while idle");

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.commit))
    else $error("result shown without commit");

  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.granted) |->
      (out_data_o.grant0 == '0 && out_data_o.grant1 == '0 && out_data_o.grant2 == '0))
    else $error("failed request carries counts");

endmodule
